/* rtl/lgrs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lgrs_pkg;

    localparam int C_ROW_W    = 64;
    localparam int C_IDX_W    = 6;
    localparam int C_SIZE_W   = 7;
    localparam int C_MAX_SIDE = 64;

    typedef logic [C_ROW_W-1:0]  t_row;
    typedef logic [C_IDX_W-1:0]  t_index;
    typedef logic [C_SIZE_W-1:0] t_size;

    typedef struct packed {
        t_row   next_row;
        t_index row_index;
        logic   frame_end;
    } t_result;

    // A written size of zero acts as one; anything above the maximum saturates.
    function automatic t_size clamp_size(input t_size value);
        t_size size;
        size = value;
        if (size == '0) begin
            size = t_size'(1);
        end
        if (size > t_size'(C_MAX_SIDE)) begin
            size = t_size'(C_MAX_SIDE);
        end
        return size;
    endfunction

    // Bit x is set when column x lies inside the board.
    function automatic t_row side_mask(input t_size size);
        t_row mask;
        for (int x = 0; x < C_ROW_W; x++) begin
            mask[x] = (t_size'(x) < size);
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

/* rtl/lgrs_row_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface lgrs_row_if;
    import lgrs_pkg::*;

    logic valid;
    logic ready;
    t_row row_cells;

    modport source (output valid, output row_cells, input ready);
    modport sink   (input valid, input row_cells, output ready);
endinterface

`default_nettype wire

/* rtl/lgrs_result_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface lgrs_result_if;
    import lgrs_pkg::*;

    logic   valid;
    logic   ready;
    t_row   next_row;
    t_index row_index;
    logic   frame_end;

    modport source (output valid, output next_row, output row_index, output frame_end,
                    input ready);
    modport sink   (input valid, input next_row, input row_index, input frame_end,
                    output ready);
endinterface

`default_nettype wire

/* rtl/lgrs_row_eval.sv */
`timescale 1ns / 1ps
`default_nettype none

module lgrs_row_eval
    import lgrs_pkg::*;
(
    input  wire t_row i_above,
    input  wire t_row i_here,
    input  wire t_row i_below,
    input  wire t_row i_mask,
    output t_row      o_next_row
);

    t_row w_a;
    t_row w_h;
    t_row w_b;
    t_row w_next;

    assign w_a = i_above & i_mask;
    assign w_h = i_here  & i_mask;
    assign w_b = i_below & i_mask;

    // Each column counts its eight neighbors on its own; columns off the edge are dead.
    always_comb begin
        logic [3:0] count;
        for (int x = 0; x < C_ROW_W; x++) begin
            count = 4'(w_a[x]) + 4'(w_b[x]);
            if (x > 0) begin
                count = count + 4'(w_a[x-1]) + 4'(w_h[x-1]) + 4'(w_b[x-1]);
            end
            if (x < C_ROW_W - 1) begin
                count = count + 4'(w_a[x+1]) + 4'(w_h[x+1]) + 4'(w_b[x+1]);
            end
            w_next[x] = (count == 4'd3) || (w_h[x] && (count == 4'd2));
        end
    end

    assign o_next_row = w_next & i_mask;

endmodule

`default_nettype wire

/* rtl/lgrs_out_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module lgrs_out_fifo
    import lgrs_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_push0,
    input  wire t_result                   i_data0,
    input  wire                            i_push1,
    input  wire t_result                   i_data1,
    output logic [$clog2(DEPTH+1)-1:0]     o_count,
    output logic                           o_valid,
    input  wire                            i_ready,
    output t_result                        o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   w_wr_p1;
    logic [AW-1:0]   w_wr_p2;
    logic [AW-1:0]   w_rd_p1;
    logic            w_pop;
    logic [AW-1:0]   n_wr_ptr;
    logic [CW-1:0]   n_count;

    assign w_wr_p1 = (r_wr_ptr == AW'(DEPTH-1)) ? '0 : r_wr_ptr + AW'(1);
    assign w_wr_p2 = (w_wr_p1  == AW'(DEPTH-1)) ? '0 : w_wr_p1  + AW'(1);
    assign w_rd_p1 = (r_rd_ptr == AW'(DEPTH-1)) ? '0 : r_rd_ptr + AW'(1);
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push0 && i_push1) begin
            n_wr_ptr = w_wr_p2;
        end else if (i_push0) begin
            n_wr_ptr = w_wr_p1;
        end
        n_count = r_count + CW'(i_push0) + CW'(i_push1) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push1) begin
            r_mem[w_wr_p1] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (w_pop) begin
                r_rd_ptr <= w_rd_p1;
            end
        end
    end

    assign o_count = r_count;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

/* rtl/life_generation_row_stream.sv */
`timescale 1ns / 1ps
`default_nettype none

// One generation of Life (born on three neighbors, survives on two or three) on a square
// board with a dead border, fed one row at a time from the top. Each row item carries one
// current-generation row; column x is bit x, and columns at or beyond the board size are
// taken as dead. Every row after the first yields the next-generation row above it, and
// the last row of the board also yields its own next row with frame_end set, after which a
// new frame begins. A one-row board yields one result per row. The board size register is
// written through i_cfg_we and i_cfg_wdata while nothing is in flight; a write of zero acts
// as one, values above 64 saturate, and every write restarts the frame. A row item is taken
// every clock cycle while i_row.ready is high: the neighbor counts for all 64 columns are
// evaluated in parallel between the input register and the result queue. The last row of
// a board produces two results, which leave the queue one after the other; i_row.ready
// falls only when the result queue holds more than OUT_DEPTH minus four results, that is
// when the consumer is holding back.
module life_generation_row_stream
    import lgrs_pkg::*;
#(
    parameter int OUT_DEPTH = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    lgrs_row_if.sink         i_row,
    lgrs_result_if.source    o_res,
    input  wire              i_cfg_we,
    input  wire t_size       i_cfg_wdata
);

    localparam int CW = $clog2(OUT_DEPTH+1);

    // Input register.
    logic          r_in_valid;
    t_row          r_in_row;

    // Frame state: the two rows held back and how many rows of the frame were seen.
    t_row          r_upper;
    t_row          r_middle;
    t_size         r_rows_seen;
    t_size         r_board;
    t_row          r_mask;

    logic          w_first;
    t_row          w_row;
    t_row          n_upper;
    t_row          n_middle;
    t_size         n_rows_seen;
    logic          w_res_a;
    logic          w_res_b;
    t_row          w_next_a;
    t_row          w_next_b;
    t_result       w_item_a;
    t_result       w_item_b;
    logic          w_push0;
    logic          w_push1;
    t_result       w_data0;
    t_result       w_data1;
    logic [CW-1:0] w_count;
    t_result       w_head;
    t_size         w_cfg_size;

    assign i_row.ready = (w_count <= CW'(OUT_DEPTH - 4));

    always_ff @(posedge i_clk) begin
        if (i_row.valid && i_row.ready) begin
            r_in_row <= i_row.row_cells;
        end
    end

    // The row in the input register is combined with the two held rows. The first row of a
    // frame only fills the window; once the count reaches the board size the last row is
    // finished against a dead row below.
    assign w_first = (r_rows_seen == '0);
    assign w_row   = r_in_row & r_mask;

    always_comb begin
        n_upper     = w_first ? '0 : r_middle;
        n_middle    = w_row;
        n_rows_seen = w_first ? t_size'(1) : r_rows_seen + t_size'(1);
    end

    assign w_res_a = r_in_valid && !w_first;
    assign w_res_b = r_in_valid && (n_rows_seen >= r_board);

    lgrs_row_eval u_eval_a (
        .i_above    (r_upper),
        .i_here     (r_middle),
        .i_below    (w_row),
        .i_mask     (r_mask),
        .o_next_row (w_next_a)
    );

    lgrs_row_eval u_eval_b (
        .i_above    (n_upper),
        .i_here     (n_middle),
        .i_below    ('0),
        .i_mask     (r_mask),
        .o_next_row (w_next_b)
    );

    always_comb begin
        w_item_a.next_row  = w_next_a;
        w_item_a.row_index = t_index'(r_rows_seen - t_size'(1));
        w_item_a.frame_end = 1'b0;
        w_item_b.next_row  = w_next_b;
        w_item_b.row_index = t_index'(r_board - t_size'(1));
        w_item_b.frame_end = 1'b1;
    end

    // The row above always leaves before the last row when both appear.
    assign w_push0 = w_res_a || w_res_b;
    assign w_push1 = w_res_a && w_res_b;
    assign w_data0 = w_res_a ? w_item_a : w_item_b;
    assign w_data1 = w_item_b;

    assign w_cfg_size = clamp_size(i_cfg_wdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_upper     <= '0;
            r_middle    <= '0;
            r_rows_seen <= '0;
            r_board     <= t_size'(C_MAX_SIDE);
            r_mask      <= side_mask(t_size'(C_MAX_SIDE));
        end else begin
            r_in_valid <= i_row.valid && i_row.ready;
            if (i_cfg_we) begin
                r_board     <= w_cfg_size;
                r_mask      <= side_mask(w_cfg_size);
                r_upper     <= '0;
                r_middle    <= '0;
                r_rows_seen <= '0;
            end else if (r_in_valid) begin
                if (w_res_b) begin
                    r_upper     <= '0;
                    r_middle    <= '0;
                    r_rows_seen <= '0;
                end else begin
                    r_upper     <= n_upper;
                    r_middle    <= n_middle;
                    r_rows_seen <= n_rows_seen;
                end
            end
        end
    end

    lgrs_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (w_push0),
        .i_data0 (w_data0),
        .i_push1 (w_push1),
        .i_data1 (w_data1),
        .o_count (w_count),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (w_head)
    );

    assign o_res.next_row  = w_head.next_row;
    assign o_res.row_index = w_head.row_index;
    assign o_res.frame_end = w_head.frame_end;

endmodule

`default_nettype wire

/* rtl/lgrs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module lgrs_checker
    import lgrs_pkg::*;
(
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         i_cfg_we,
    input wire t_size  i_cfg_wdata,
    input wire         i_out_valid,
    input wire         i_out_ready,
    input wire t_row   i_next_row,
    input wire t_index i_row_index,
    input wire         i_frame_end
);

    t_size r_board;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board <= t_size'(C_MAX_SIDE);
        end else if (i_cfg_we) begin
            r_board <= clamp_size(i_cfg_wdata);
        end
    end

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_frame_end) |-> (t_size'(i_row_index) == r_board - t_size'(1)))
        else $error("last row of a frame carries the wrong row index");

    a_inner_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_frame_end) |-> (t_size'(i_row_index) < r_board - t_size'(1)))
        else $error("inner row index reaches the last row of the board");

    a_dead_margin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_next_row & ~side_mask(r_board)) == '0))
        else $error("live cell outside the board");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_next_row) && $stable(i_row_index)
             && $stable(i_frame_end)))
        else $error("stalled result changed");

endmodule

bind life_generation_row_stream lgrs_checker u_lgrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_wdata (i_cfg_wdata),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_next_row  (o_res.next_row),
    .i_row_index (o_res.row_index),
    .i_frame_end (o_res.frame_end)
);

`default_nettype wire
